// File: rtl/cts_pkg.sv
// ----------------------------------------------------------------------------
// cts_pkg: shared types and constants of the C token scanner
// Token codes, scanner modes and the result record.
// ----------------------------------------------------------------------------
`default_nettype none
package cts_pkg;
    localparam int COLUMN_BITS = 16;
    localparam int LINE_BITS   = 32;

    localparam logic [5:0] K_END      = 6'd0;
    localparam logic [5:0] K_ID       = 6'd1;
    localparam logic [5:0] K_INT      = 6'd2;
    localparam logic [5:0] K_FLOAT    = 6'd8;
    localparam logic [5:0] K_DOUBLE   = 6'd9;
    localparam logic [5:0] K_LDOUBLE  = 6'd10;
    localparam logic [5:0] K_DIV_ASG  = 6'd20;
    localparam logic [5:0] K_DIV      = 6'd21;
    localparam logic [5:0] K_ELLIPSIS = 6'd44;
    localparam logic [5:0] K_DOT      = 6'd45;
    localparam logic [5:0] K_ERROR    = 6'd57;

    localparam logic [1:0] E_NONE    = 2'd0;
    localparam logic [1:0] E_ILLEGAL = 2'd1;
    localparam logic [1:0] E_NOHEX   = 2'd2;
    localparam logic [1:0] E_UNTERM  = 2'd3;

    typedef enum logic [4:0] {
        M_WS, M_SLASH, M_LCOM, M_BCOM, M_BSTAR, M_PP, M_IDENT, M_ZERO, M_HEXX,
        M_HEX, M_OCT, M_DEC, M_SUFU, M_SUFL, M_FRAC, M_EXP, M_EXPS, M_EXPD,
        M_DOTS, M_PLUS, M_MINUS, M_STAR, M_PCT, M_LESS, M_SHL, M_GREAT, M_SHR,
        M_BANG, M_EQ, M_BAR, M_AMP, M_CARET
    } mode_t;

    typedef struct packed {
        logic [5:0]             kind;
        logic [31:0]            value;
        logic                   big;
        logic [1:0]             err;
        logic [15:0]            len;
        logic [LINE_BITS-1:0]   line;
        logic [COLUMN_BITS-1:0] col;
        logic                   last;
    } tok_t;

    // Group of up to four results produced by one byte.
    typedef struct packed {
        logic [2:0]   count;
        tok_t [3:0]   tok;
    } grp_t;
endpackage
`default_nettype wire

// File: rtl/cts_front.sv
// ----------------------------------------------------------------------------
// cts_front: byte scanner
// Takes one byte a cycle while take is high, updates the scanner state and forms its tokens.
// ----------------------------------------------------------------------------
`default_nettype none
module cts_front
    import cts_pkg::*;
(
    input  wire  logic       clk,
    input  wire  logic       rst_n,
    input  wire  logic       take,
    input  wire  logic [7:0] src_byte,
    input  wire  logic       end_of_input,
    output grp_t             grp
);
    localparam logic [COLUMN_BITS-1:0] COL_MAX = '1;
    localparam logic [LINE_BITS-1:0]   LIN_MAX = '1;

    mode_t                  mode_reg, mode_next;
    logic [1:0]             dots_reg, dots_next;
    logic [31:0]            val_reg, val_next;
    logic                   ovf_reg, ovf_next;
    logic [1:0]             base_reg, base_next;
    logic [2:0]             suf_reg, suf_next;
    logic [LINE_BITS-1:0]   line_reg, line_next, sline_reg, sline_next;
    logic [COLUMN_BITS-1:0] col_reg, col_next, scol_reg, scol_next;
    logic [15:0]            len_reg, len_next;

    function automatic logic [COLUMN_BITS-1:0] sat_col(input logic [COLUMN_BITS-1:0] x);
        return (x == COL_MAX) ? COL_MAX : x + 1'b1;
    endfunction

    function automatic logic is_dig(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_let(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        logic [7:0] l;
        l = c | 8'h20;
        return is_dig(c) || (l >= "a" && l <= "f");
    endfunction

    always_comb
    begin
        logic [7:0]  c;
        logic        done;
        logic [35:0] prod;
        logic [3:0]  dig;
        logic        do_acc;
        logic        two;
        c = src_byte;
        mode_next = mode_reg;
        dots_next = dots_reg;
        val_next = val_reg;
        ovf_next = ovf_reg;
        base_next = base_reg;
        suf_next = suf_reg;
        sline_next = sline_reg;
        scol_next = scol_reg;
        len_next = len_reg;
        grp = '0;
        do_acc = 1'b0;
        dig = '0;
        two = 1'b0;
        prod = '0;
        // Each byte is looked at up to three times: a pair of dots with no
        // third closes one dot and rescans as a single dot, which may close
        // again, and the byte then starts over from whitespace mode.
        done = 1'b0;
        for (int t = 0; t < 3; t++)
        begin
            if (!done)
            begin
                done = 1'b1;
                case (mode_next)
                    M_WS:
                    begin
                        if (!(c == " " || c == 8'h09 || c == 8'h0B || c == 8'h0C ||
                              c == 8'h0D || c == 8'h0A))
                        begin
                            if (c == "#")
                                mode_next = M_PP;
                            else
                            begin
                                sline_next = line_reg;
                                scol_next = col_reg;
                                len_next = 16'd1;
                                case (c)
                                    "/": mode_next = M_SLASH;
                                    ".": begin mode_next = M_DOTS; dots_next = 2'd1; end
                                    "+": mode_next = M_PLUS;
                                    "-": mode_next = M_MINUS;
                                    "*": mode_next = M_STAR;
                                    "%": mode_next = M_PCT;
                                    "<": mode_next = M_LESS;
                                    ">": mode_next = M_GREAT;
                                    "!": mode_next = M_BANG;
                                    "=": mode_next = M_EQ;
                                    "|": mode_next = M_BAR;
                                    "&": mode_next = M_AMP;
                                    "^": mode_next = M_CARET;
                                    "{": emit(6'd46, E_NONE);
                                    "}": emit(6'd47, E_NONE);
                                    "[": emit(6'd48, E_NONE);
                                    "]": emit(6'd49, E_NONE);
                                    "(": emit(6'd50, E_NONE);
                                    ")": emit(6'd51, E_NONE);
                                    ",": emit(6'd52, E_NONE);
                                    ";": emit(6'd53, E_NONE);
                                    "~": emit(6'd54, E_NONE);
                                    "?": emit(6'd55, E_NONE);
                                    ":": emit(6'd56, E_NONE);
                                    default:
                                    begin
                                        if (is_let(c))
                                            mode_next = M_IDENT;
                                        else if (c == "0")
                                        begin
                                            base_next = 2'd1; val_next = '0;
                                            ovf_next = 1'b0; suf_next = '0;
                                            mode_next = M_ZERO;
                                        end
                                        else if (is_dig(c))
                                        begin
                                            base_next = 2'd0; ovf_next = 1'b0;
                                            suf_next = '0;
                                            val_next = {28'd0, c[3:0]};
                                            mode_next = M_DEC;
                                        end
                                        else
                                            emit(K_ERROR, E_ILLEGAL);
                                    end
                                endcase
                            end
                        end
                    end
                    M_SLASH:
                    begin
                        if (c == "/") mode_next = M_LCOM;
                        else if (c == "*") begin ext(); mode_next = M_BCOM; end
                        else if (c == "=") begin ext(); emit(K_DIV_ASG, E_NONE); end
                        else begin emit(K_DIV, E_NONE); done = 1'b0; end
                    end
                    M_LCOM, M_PP:
                        if (c == 8'h0A) mode_next = M_WS;
                    M_BCOM:
                    begin
                        ext();
                        if (c == "*") mode_next = M_BSTAR;
                    end
                    M_BSTAR:
                    begin
                        ext();
                        if (c == "/") mode_next = M_WS;
                        else if (c != "*") mode_next = M_BCOM;
                    end
                    M_IDENT:
                        if (is_let(c) || is_dig(c)) ext();
                        else begin emit(K_ID, E_NONE); done = 1'b0; end
                    M_ZERO, M_OCT, M_DEC:
                    begin
                        if (mode_next == M_ZERO && (c == "x" || c == "X"))
                        begin
                            ext(); base_next = 2'd2; mode_next = M_HEXX;
                        end
                        else if (((mode_next != M_DEC) && c >= "0" && c <= "7") ||
                                 (mode_next == M_DEC && is_dig(c)))
                        begin
                            ext(); do_acc = 1'b1; dig = c[3:0];
                            if (mode_next == M_ZERO) mode_next = M_OCT;
                        end
                        else if (c == ".") begin ext(); mode_next = M_FRAC; end
                        else int_tail(c, done);
                    end
                    M_HEXX, M_HEX:
                    begin
                        if (is_hex(c))
                        begin
                            ext(); do_acc = 1'b1;
                            dig = is_dig(c) ? c[3:0] : c[3:0] + 4'd9;
                            mode_next = M_HEX;
                        end
                        else if (mode_next == M_HEXX)
                        begin
                            val_next = '0; ovf_next = 1'b0; suf_next = '0;
                            emit(K_INT, E_NOHEX); done = 1'b0;
                        end
                        else int_tail(c, done);
                    end
                    M_SUFU:
                        if (c == "L" || c == "l")
                        begin
                            suf_next = 3'd3; ext(); mode_next = M_SUFL;
                        end
                        else begin emit_int(); done = 1'b0; end
                    M_SUFL:
                        if (c == "L" || c == "l")
                        begin
                            ext();
                            suf_next = (suf_next == 3'd3) ? 3'd5 : 3'd4;
                            emit_int();
                        end
                        else begin emit_int(); done = 1'b0; end
                    M_FRAC, M_EXP, M_EXPS, M_EXPD:
                    begin
                        if (is_dig(c))
                        begin
                            ext();
                            if (mode_next != M_FRAC) mode_next = M_EXPD;
                        end
                        else if (mode_next == M_FRAC && (c == "e" || c == "E"))
                        begin
                            ext(); mode_next = M_EXP;
                        end
                        else if (mode_next == M_EXP && (c == "+" || c == "-"))
                        begin
                            ext(); mode_next = M_EXPS;
                        end
                        else if (c == "f" || c == "F") begin ext(); emit(K_FLOAT, E_NONE); end
                        else if (c == "l" || c == "L") begin ext(); emit(K_LDOUBLE, E_NONE); end
                        else begin emit(K_DOUBLE, E_NONE); done = 1'b0; end
                    end
                    M_DOTS:
                    begin
                        if (dots_next == 2'd2)
                        begin
                            if (c == ".") begin ext(); emit(K_ELLIPSIS, E_NONE); end
                            else
                            begin
                                len_next = 16'd1;
                                emit(K_DOT, E_NONE);
                                scol_next = sat_col(scol_next);
                                mode_next = M_DOTS;
                                dots_next = 2'd1;
                                done = 1'b0;
                            end
                        end
                        else if (c == ".") begin ext(); dots_next = 2'd2; end
                        else if (is_dig(c))
                        begin
                            ext(); dots_next = 2'd0; mode_next = M_FRAC;
                        end
                        else begin emit(K_DOT, E_NONE); done = 1'b0; end
                    end
                    default:
                        op_step(c, done);
                endcase
            end
        end
        // The digit accumulate happens at most once per byte.
        if (do_acc)
        begin
            case (base_next)
                2'd2:    prod = {val_next, 4'd0};
                2'd1:    prod = {1'b0, val_next, 3'd0};
                default: prod = {1'b0, val_next, 3'd0} + {3'd0, val_next, 1'b0};
            endcase
            prod = prod + {32'd0, dig};
            if (prod[35:32] != 4'd0) ovf_next = 1'b1;
            val_next = prod[31:0];
        end
        line_next = line_reg;
        col_next = col_reg;
        if (c == 8'h0A)
        begin
            if (line_reg != LIN_MAX) line_next = line_reg + 1'b1;
            col_next = {{(COLUMN_BITS-1){1'b0}}, 1'b1};
        end
        else
            col_next = sat_col(col_reg);
        if (end_of_input)
        begin
            case (mode_next)
                M_SLASH:        emit(K_DIV, E_NONE);
                M_BCOM, M_BSTAR: emit(K_ERROR, E_UNTERM);
                M_IDENT:        emit(K_ID, E_NONE);
                M_HEXX:
                begin
                    val_next = '0; ovf_next = 1'b0; suf_next = '0;
                    emit(K_INT, E_NOHEX);
                end
                M_ZERO, M_HEX, M_OCT, M_DEC, M_SUFU, M_SUFL: emit_int();
                M_FRAC, M_EXP, M_EXPS, M_EXPD: emit(K_DOUBLE, E_NONE);
                M_DOTS:
                begin
                    two = dots_next == 2'd2;
                    len_next = 16'd1;
                    emit(K_DOT, E_NONE);
                    if (two)
                    begin
                        scol_next = sat_col(scol_next);
                        emit(K_DOT, E_NONE);
                    end
                end
                M_WS, M_LCOM, M_PP: ;
                default: op_flush();
            endcase
            put(K_END, '0, 1'b0, E_NONE, '0, line_next, col_next, 1'b1);
            mode_next = M_WS; dots_next = '0; val_next = '0; ovf_next = 1'b0;
            base_next = '0; suf_next = '0; line_next = {{(LINE_BITS-1){1'b0}}, 1'b1};
            col_next = {{(COLUMN_BITS-1){1'b0}}, 1'b1};
            sline_next = {{(LINE_BITS-1){1'b0}}, 1'b1};
            scol_next = {{(COLUMN_BITS-1){1'b0}}, 1'b1};
            len_next = '0;
        end
    end

    // Helpers that act on the next-state signals of the block above.
    function automatic void put(input logic [5:0] k, input logic [31:0] v, input logic b,
                                input logic [1:0] e, input logic [15:0] l,
                                input logic [LINE_BITS-1:0] ln,
                                input logic [COLUMN_BITS-1:0] cl, input logic last);
        tok_t r;
        r.kind = k; r.value = v; r.big = b; r.err = e; r.len = l;
        r.line = ln; r.col = cl; r.last = last;
        if (grp.count != 3'd4)
        begin
            grp.tok[grp.count[1:0]] = r;
            grp.count = grp.count + 3'd1;
        end
    endfunction

    function automatic void emit(input logic [5:0] k, input logic [1:0] e);
        put(k, '0, 1'b0, e, len_next, sline_next, scol_next, 1'b0);
        mode_next = M_WS;
        dots_next = '0;
    endfunction

    function automatic void emit_int();
        logic [5:0] k;
        k = K_INT + ((suf_next > 3'd5) ? 6'd0 : {3'd0, suf_next});
        put(k, val_next, ovf_next, E_NONE, len_next, sline_next, scol_next, 1'b0);
        mode_next = M_WS;
        dots_next = '0;
    endfunction

    function automatic void ext();
        if (len_next != 16'hFFFF) len_next = len_next + 16'd1;
    endfunction

    function automatic void int_tail(input logic [7:0] c, inout logic dn);
        if (c == "U" || c == "u") begin suf_next = 3'd1; ext(); mode_next = M_SUFU; end
        else if (c == "L" || c == "l") begin suf_next = 3'd2; ext(); mode_next = M_SUFL; end
        else begin emit_int(); dn = 1'b0; end
    endfunction

    function automatic logic [5:0] op_dflt(input mode_t m);
        case (m)
            M_PLUS:  return 6'd13;
            M_MINUS: return 6'd17;
            M_STAR:  return 6'd19;
            M_PCT:   return 6'd23;
            M_LESS:  return 6'd27;
            M_SHL:   return 6'd26;
            M_GREAT: return 6'd31;
            M_SHR:   return 6'd30;
            M_BANG:  return 6'd33;
            M_EQ:    return 6'd35;
            M_BAR:   return 6'd38;
            M_AMP:   return 6'd41;
            M_CARET: return 6'd43;
            default: return K_ERROR;
        endcase
    endfunction

    function automatic void op_flush();
        emit(op_dflt(mode_next), E_NONE);
    endfunction

    function automatic void op_step(input logic [7:0] c, inout logic dn);
        logic [5:0] k;
        logic       more;
        k = '0;
        more = 1'b0;
        if (c == "=")
        begin
            case (mode_next)
                M_PLUS: k = 6'd11; M_MINUS: k = 6'd14; M_STAR: k = 6'd18;
                M_PCT: k = 6'd22; M_LESS: k = 6'd24; M_SHL: k = 6'd25;
                M_GREAT: k = 6'd28; M_SHR: k = 6'd29; M_BANG: k = 6'd32;
                M_EQ: k = 6'd34; M_BAR: k = 6'd36; M_AMP: k = 6'd39;
                M_CARET: k = 6'd42;
                default: k = '0;
            endcase
        end
        else if (c == "+" && mode_next == M_PLUS) k = 6'd12;
        else if (c == "-" && mode_next == M_MINUS) k = 6'd15;
        else if (c == ">" && mode_next == M_MINUS) k = 6'd16;
        else if (c == "|" && mode_next == M_BAR) k = 6'd37;
        else if (c == "&" && mode_next == M_AMP) k = 6'd40;
        else if ((c == "<" && mode_next == M_LESS) || (c == ">" && mode_next == M_GREAT))
            more = 1'b1;
        if (more)
        begin
            ext();
            mode_next = (mode_next == M_LESS) ? M_SHL : M_SHR;
        end
        else if (k != '0)
        begin
            ext();
            emit(k, E_NONE);
        end
        else
        begin
            op_flush();
            dn = 1'b0;
        end
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_WS;
            dots_reg <= '0;
            val_reg <= '0;
            ovf_reg <= 1'b0;
            base_reg <= '0;
            suf_reg <= '0;
            line_reg <= {{(LINE_BITS-1){1'b0}}, 1'b1};
            col_reg <= {{(COLUMN_BITS-1){1'b0}}, 1'b1};
            sline_reg <= {{(LINE_BITS-1){1'b0}}, 1'b1};
            scol_reg <= {{(COLUMN_BITS-1){1'b0}}, 1'b1};
            len_reg <= '0;
        end
        else if (take)
        begin
            mode_reg <= mode_next;
            dots_reg <= dots_next;
            val_reg <= val_next;
            ovf_reg <= ovf_next;
            base_reg <= base_next;
            suf_reg <= suf_next;
            line_reg <= line_next;
            col_reg <= col_next;
            sline_reg <= sline_next;
            scol_reg <= scol_next;
            len_reg <= len_next;
        end
    end
endmodule
`default_nettype wire

// File: rtl/cts_queue.sv
// ----------------------------------------------------------------------------
// cts_queue: token group queue
// Four-entry queue of result groups between scanner and output stage.
// ----------------------------------------------------------------------------
`default_nettype none
module cts_queue
    import cts_pkg::*;
(
    input  wire  logic clk,
    input  wire  logic rst_n,
    input  wire  logic wr,
    input  wire  grp_t wr_grp,
    output logic       full,
    output logic       avail,
    input  wire  logic rd,
    output grp_t       rd_grp
);
    grp_t       mem [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;

    assign full = cnt_reg == 3'd4;
    assign avail = cnt_reg != 3'd0;
    assign rd_grp = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr)
            mem[wp_reg] <= wr_grp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr) wp_reg <= wp_reg + 2'd1;
            if (rd) rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + {2'd0, wr} - {2'd0, rd};
        end
    end
endmodule
`default_nettype wire

// File: rtl/cts_back.sv
// ----------------------------------------------------------------------------
// cts_back: token output stage
// Unpacks one queued group into single result items.
// ----------------------------------------------------------------------------
`default_nettype none
module cts_back
    import cts_pkg::*;
(
    input  wire  logic clk,
    input  wire  logic rst_n,
    input  wire  logic avail,
    input  wire  grp_t grp,
    output logic       rd,
    output logic       empty,
    input  wire  logic pop,
    output tok_t       tok
);
    logic [1:0] idx_reg;
    logic       last_one;

    assign empty = !avail;
    assign tok = grp.tok[idx_reg];
    assign last_one = {1'b0, idx_reg} + 3'd1 == grp.count;
    assign rd = avail && pop && last_one;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else if (avail && pop)
            idx_reg <= last_one ? 2'd0 : idx_reg + 2'd1;
    end
endmodule
`default_nettype wire

// File: rtl/c_token_scanner.sv
// ----------------------------------------------------------------------------
// c_token_scanner: byte-serial C tokenizer
// Skips whitespace, comments and preprocessor lines, emits tokens with positions.
// ----------------------------------------------------------------------------
// Usage: the source enters one byte per cycle through push/full while full is
// low; each item is a byte with an end_of_input flag on the final byte. Tokens
// leave through empty/pop as a queue: the oldest token sits on the result ports
// while empty is low and is taken by pop.
// The scanner accepts one byte every cycle while full is low. A byte yields
// zero to four tokens, which are stored as one group in a four-entry queue;
// the group is registered into the queue when its byte is taken. The output
// stage hands out one token per cycle while pop is high and empty is low, so a
// byte that yields several tokens holds its queue slot until all are popped.
// When the receiver stalls, the queue fills and full rises; the scanner then
// holds its state. Reset empties the queue and returns the scanner to line 1,
// column 1, between tokens.
// ----------------------------------------------------------------------------
`default_nettype none
module c_token_scanner
    import cts_pkg::*;
(
    input  wire  logic                   clk,
    input  wire  logic                   rst_n,
    input  wire  logic                   push,
    output logic                         full,
    input  wire  logic [7:0]             src_byte,
    input  wire  logic                   end_of_input,
    output logic                         empty,
    input  wire  logic                   pop,
    output logic [5:0]                   token_kind,
    output logic [31:0]                  int_value,
    output logic                         too_big,
    output logic [1:0]                   error_code,
    output logic [15:0]                  token_length,
    output logic [LINE_BITS-1:0]         token_line,
    output logic [COLUMN_BITS-1:0]       token_column,
    output logic                         last_of_run
);
    grp_t grp, qgrp;
    logic take, wr, avail, rd;
    tok_t tok;

    assign take = push && !full;
    // Bytes with no token need no queue slot.
    assign wr = take && grp.count != 3'd0;

    cts_front u_front (
        .clk(clk), .rst_n(rst_n), .take(take), .src_byte(src_byte),
        .end_of_input(end_of_input), .grp(grp)
    );

    cts_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr(wr), .wr_grp(grp), .full(full),
        .avail(avail), .rd(rd), .rd_grp(qgrp)
    );

    cts_back u_back (
        .clk(clk), .rst_n(rst_n), .avail(avail), .grp(qgrp), .rd(rd),
        .empty(empty), .pop(pop), .tok(tok)
    );

    assign token_kind = tok.kind;
    assign int_value = tok.value;
    assign too_big = tok.big;
    assign error_code = tok.err;
    assign token_length = tok.len;
    assign token_line = tok.line;
    assign token_column = tok.col;
    assign last_of_run = tok.last;
endmodule
`default_nettype wire
